// File: hw/rtl/drs_pkg.sv
// ----------------------------------------------------------------------------
// drs_pkg: shared types and constants of the dirty rectangle set
// Pool and stack sizes, payload structs, opcodes, controller commands,
// datapath status and controller states.
// ----------------------------------------------------------------------------
package drs_pkg;

    localparam int POOL_DEPTH  = 32;
    localparam int STACK_DEPTH = 128;
    localparam int PTR_W       = $clog2(POOL_DEPTH + 1);
    localparam int IDX_W       = $clog2(POOL_DEPTH);
    localparam int SP_W        = $clog2(STACK_DEPTH + 1);
    localparam int SIDX_W      = $clog2(STACK_DEPTH);
    localparam logic [PTR_W-1:0] NODE_END = PTR_W'(POOL_DEPTH);

    typedef logic signed [15:0] coord_t;

    typedef struct packed {
        coord_t l;
        coord_t t;
        coord_t r;
        coord_t b;
    } box_t;

    typedef enum logic [2:0] {
        OP_CLEAR      = 3'd0,
        OP_ADD_MERGE  = 3'd1,
        OP_WHOLE      = 3'd2,
        OP_REMOVE     = 3'd3,
        OP_QUERY      = 3'd4,
        OP_READ_FIRST = 3'd5,
        OP_READ_NEXT  = 3'd6,
        OP_ADD_DIRECT = 3'd7
    } op_t;

    typedef enum logic [1:0] {
        CFG_LEFT   = 2'd0,
        CFG_TOP    = 2'd1,
        CFG_RIGHT  = 2'd2,
        CFG_BOTTOM = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [2:0] opcode;
        coord_t     left_edge;
        coord_t     top_edge;
        coord_t     right_edge;
        coord_t     bottom_edge;
    } in_item_t;

    typedef struct packed {
        logic       hit;
        logic       rect_valid;
        coord_t     out_left;
        coord_t     out_top;
        coord_t     out_right;
        coord_t     out_bottom;
        logic       whole_mode;
        logic [5:0] stored_count;
    } out_item_t;

    typedef enum logic [4:0] {
        C_NOP,
        C_ACCEPT,
        C_CLEAR,
        C_WHOLE,
        C_LOAD_X,
        C_CLIP,
        C_PUSH_IN,
        C_POP,
        C_PUSH,
        C_NODE_HEAD,
        C_NODE_NEXT,
        C_NODE_LINK,
        C_UNLINK,
        C_ALLOC,
        C_LINK_PREV,
        C_LINK_SLOT,
        C_LOAD_RP,
        C_RRESTORE,
        C_CUR_HEAD,
        C_CUR_NEXT,
        C_NODE_CUR,
        C_CUR_END,
        C_HIT,
        C_RES,
        C_PUBLISH
    } dp_op_t;

    typedef struct packed {
        dp_op_t     op;
        logic [1:0] sel;
    } cmd_t;

    typedef struct packed {
        op_t        op;
        logic       whole;
        logic       full;
        logic       raw_empty;
        logic       node_end;
        logic       head_end;
        logic       cursor_end;
        logic       cursor_used;
        logic       count_zero;
        logic       sp_zero;
        logic       sp_full;
        logic       rprev_end;
        logic       ov;
        logic       x_in_c;
        logic       c_in_x;
        logic       ins_lt;
        logic       ins_le;
        logic       below;
        logic       ov_q;
        logic [3:0] split_need;
        logic [3:0] rem_need;
    } status_t;

    typedef enum logic [5:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_FINISH,
        ST_ADM,
        ST_ADM2,
        ST_RET,
        ST_INS,
        ST_I_W1WAIT,
        ST_I_W1,
        ST_I_W2WAIT,
        ST_I_W2,
        ST_I_LP,
        ST_I_LS,
        ST_M_POPWAIT,
        ST_M_POP,
        ST_M_SCAN,
        ST_M_WAIT,
        ST_M_VIS,
        ST_M_SPLIT,
        ST_R_WAIT,
        ST_R_VIS,
        ST_R_PIECE,
        ST_R_END,
        ST_R_RESUME,
        ST_R_RLWAIT,
        ST_R_RL,
        ST_Q_CLIP,
        ST_Q_CHK,
        ST_Q_WAIT,
        ST_Q_VIS,
        ST_RF_WAIT,
        ST_RF_RES,
        ST_RN_WAIT,
        ST_RN_LINK,
        ST_RN_CHK
    } state_t;

    function automatic coord_t cmax(coord_t a, coord_t b);
        return (a > b) ? a : b;
    endfunction

    function automatic coord_t cmin(coord_t a, coord_t b);
        return (a < b) ? a : b;
    endfunction

    function automatic box_t clip_box(box_t x, box_t bd);
        box_t y;
        y.l = cmax(x.l, bd.l);
        y.t = cmax(x.t, bd.t);
        y.r = cmin(x.r, bd.r);
        y.b = cmin(x.b, bd.b);
        return y;
    endfunction

endpackage

// File: hw/rtl/dirty_rectangle_set_top.sv
// ----------------------------------------------------------------------------
// dirty_rectangle_set_top: screen damage rectangle set
// Keeps up to 32 damage rectangles in top/left order, merge adds without
// overlap, with whole-screen mode, direct adds, remove, query and reads.
// ----------------------------------------------------------------------------
// Usage:
//   Commands enter on in_valid/in_ready, one transfer per operation; each
//   produces exactly one result transfer on out_valid/out_ready.
//   cfg_valid/cfg_index/cfg_data write the clipping border (left, top,
//   right, bottom); cfg_ready is always high. Write it only while idle.
//   One operation is in work at a time. Query, add and remove walk the
//   linked list through the pool memories node by node, and a merging
//   add or a remove also works through the pieces it splits off.
//   in_ready rises again as soon as the result sits in the output register,
//   so the next command is taken while that result waits; a later result
//   holds until the receiver takes the earlier one.
//   Reset empties the set, leaves whole mode, zeroes the border and clears
//   out_valid. No memory clearing pass is needed.
// ----------------------------------------------------------------------------
module dirty_rectangle_set_top (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  drs_pkg::in_item_t   in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output drs_pkg::out_item_t  out_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  drs_pkg::cfg_idx_t   cfg_index,
    input  drs_pkg::coord_t     cfg_data
);
    import drs_pkg::*;

    cmd_t    cmd;
    status_t status;

    assign cfg_ready = 1'b1;

    drs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    drs_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .out_data  (out_data)
    );

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken again right after a transfer");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.stored_count <= 6'(POOL_DEPTH))
        else $error("stored count above pool size");

    a_whole_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.whole_mode |-> out_data.stored_count == 6'd0)
        else $error("rectangles held in whole mode");

    a_pool_count: assert property (@(posedge clk) disable iff (!rst_n)
        status.count_zero |-> status.head_end)
        else $error("list not empty with zero count");

endmodule

// File: hw/rtl/drs_ctrl.sv
// ----------------------------------------------------------------------------
// drs_ctrl: operation sequencer
// Walks each operation through admit, list scan, split, insert, remove,
// query and read steps, one datapath command per cycle, owns both handshakes.
// ----------------------------------------------------------------------------
module drs_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  drs_pkg::status_t  status,
    output drs_pkg::cmd_t     cmd
);
    import drs_pkg::*;

    state_t     state_reg, state_next;
    logic [1:0] pc_reg, pc_next;
    logic       out_valid_reg, out_valid_next;
    logic       publish;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pc_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pc_reg        <= pc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        pc_next    = pc_reg;
        cmd.op     = C_NOP;
        cmd.sel    = pc_reg;
        publish    = 1'b0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op     = C_ACCEPT;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                unique case (status.op)
                    OP_CLEAR:
                    begin
                        cmd.op     = C_CLEAR;
                        state_next = ST_FINISH;
                    end
                    OP_WHOLE:
                    begin
                        cmd.op     = C_WHOLE;
                        state_next = ST_FINISH;
                    end
                    OP_ADD_MERGE:
                    begin
                        cmd.op     = C_PUSH_IN;
                        state_next = ST_M_POPWAIT;
                    end
                    OP_ADD_DIRECT:
                    begin
                        cmd.op     = C_LOAD_X;
                        state_next = ST_ADM;
                    end
                    OP_REMOVE:
                    begin
                        if (status.count_zero)
                        begin
                            state_next = ST_FINISH;
                        end
                        else
                        begin
                            cmd.op     = C_NODE_HEAD;
                            state_next = ST_R_WAIT;
                        end
                    end
                    OP_QUERY:
                    begin
                        if (status.whole)
                        begin
                            cmd.op     = C_HIT;
                            state_next = ST_FINISH;
                        end
                        else
                        begin
                            cmd.op     = C_LOAD_X;
                            state_next = ST_Q_CLIP;
                        end
                    end
                    OP_READ_FIRST:
                    begin
                        if (status.head_end)
                        begin
                            state_next = ST_FINISH;
                        end
                        else
                        begin
                            cmd.op     = C_CUR_HEAD;
                            state_next = ST_RF_WAIT;
                        end
                    end
                    OP_READ_NEXT:
                    begin
                        if (status.cursor_end || !status.cursor_used)
                        begin
                            cmd.op     = C_CUR_END;
                            state_next = ST_FINISH;
                        end
                        else
                        begin
                            cmd.op     = C_NODE_CUR;
                            state_next = ST_RN_WAIT;
                        end
                    end
                endcase
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.op     = C_PUBLISH;
                    publish    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_ADM:
            begin
                if (status.whole)
                begin
                    state_next = ST_RET;
                end
                else if (status.full)
                begin
                    cmd.op     = C_WHOLE;
                    state_next = ST_RET;
                end
                else if (status.raw_empty)
                begin
                    state_next = ST_RET;
                end
                else
                begin
                    cmd.op     = C_CLIP;
                    state_next = ST_ADM2;
                end
            end
            ST_ADM2:
            begin
                if (status.raw_empty)
                begin
                    state_next = ST_RET;
                end
                else if (status.op == OP_ADD_MERGE)
                begin
                    state_next = ST_M_SCAN;
                end
                else
                begin
                    state_next = ST_INS;
                end
            end
            ST_RET:
            begin
                unique case (status.op)
                    OP_ADD_MERGE:
                    begin
                        state_next = ST_M_POPWAIT;
                    end
                    OP_REMOVE:
                    begin
                        if (pc_reg == 2'd3)
                        begin
                            state_next = ST_R_END;
                        end
                        else
                        begin
                            pc_next    = pc_reg + 2'd1;
                            state_next = ST_R_PIECE;
                        end
                    end
                    default:
                    begin
                        state_next = ST_FINISH;
                    end
                endcase
            end
            ST_INS:
            begin
                cmd.op     = C_ALLOC;
                state_next = ST_I_W1WAIT;
            end
            ST_I_W1WAIT:
            begin
                state_next = ST_I_W1;
            end
            ST_I_W1:
            begin
                if (status.node_end)
                begin
                    state_next = ST_I_LP;
                end
                else if (status.ins_lt)
                begin
                    cmd.op     = C_NODE_NEXT;
                    state_next = ST_I_W1WAIT;
                end
                else
                begin
                    state_next = ST_I_W2;
                end
            end
            ST_I_W2WAIT:
            begin
                state_next = ST_I_W2;
            end
            ST_I_W2:
            begin
                if (!status.node_end && status.ins_le)
                begin
                    cmd.op     = C_NODE_NEXT;
                    state_next = ST_I_W2WAIT;
                end
                else
                begin
                    state_next = ST_I_LP;
                end
            end
            ST_I_LP:
            begin
                cmd.op     = C_LINK_PREV;
                state_next = ST_I_LS;
            end
            ST_I_LS:
            begin
                cmd.op     = C_LINK_SLOT;
                state_next = ST_RET;
            end
            ST_M_POPWAIT:
            begin
                state_next = ST_M_POP;
            end
            ST_M_POP:
            begin
                if (status.sp_zero || status.whole)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    cmd.op     = C_POP;
                    state_next = ST_ADM;
                end
            end
            ST_M_SCAN:
            begin
                cmd.op     = C_NODE_HEAD;
                state_next = ST_M_WAIT;
            end
            ST_M_WAIT:
            begin
                state_next = ST_M_VIS;
            end
            ST_M_VIS:
            begin
                if (status.node_end)
                begin
                    state_next = ST_INS;
                end
                else if (status.ov)
                begin
                    if (status.x_in_c)
                    begin
                        state_next = ST_M_POPWAIT;
                    end
                    else if (status.c_in_x)
                    begin
                        cmd.op     = C_UNLINK;
                        state_next = ST_ADM;
                    end
                    else
                    begin
                        pc_next    = 2'd0;
                        state_next = ST_M_SPLIT;
                    end
                end
                else
                begin
                    cmd.op     = C_NODE_NEXT;
                    state_next = ST_M_WAIT;
                end
            end
            ST_M_SPLIT:
            begin
                if (status.split_need[pc_reg] && status.sp_full)
                begin
                    cmd.op     = C_WHOLE;
                    state_next = ST_FINISH;
                end
                else
                begin
                    if (status.split_need[pc_reg])
                    begin
                        cmd.op = C_PUSH;
                    end
                    if (pc_reg == 2'd3)
                    begin
                        state_next = ST_M_POPWAIT;
                    end
                    else
                    begin
                        pc_next = pc_reg + 2'd1;
                    end
                end
            end
            ST_R_WAIT:
            begin
                state_next = ST_R_VIS;
            end
            ST_R_VIS:
            begin
                if (status.node_end)
                begin
                    state_next = ST_FINISH;
                end
                else if (status.ov_q)
                begin
                    cmd.op     = C_UNLINK;
                    pc_next    = 2'd0;
                    state_next = ST_R_PIECE;
                end
                else
                begin
                    cmd.op     = C_NODE_NEXT;
                    state_next = ST_R_WAIT;
                end
            end
            ST_R_PIECE:
            begin
                if (status.rem_need[pc_reg])
                begin
                    cmd.op     = C_LOAD_RP;
                    state_next = ST_ADM;
                end
                else if (pc_reg == 2'd3)
                begin
                    state_next = ST_R_END;
                end
                else
                begin
                    pc_next = pc_reg + 2'd1;
                end
            end
            ST_R_END:
            begin
                state_next = status.whole ? ST_FINISH : ST_R_RESUME;
            end
            ST_R_RESUME:
            begin
                cmd.op     = C_RRESTORE;
                state_next = status.rprev_end ? ST_R_WAIT : ST_R_RLWAIT;
            end
            ST_R_RLWAIT:
            begin
                state_next = ST_R_RL;
            end
            ST_R_RL:
            begin
                cmd.op     = C_NODE_LINK;
                state_next = ST_R_WAIT;
            end
            ST_Q_CLIP:
            begin
                cmd.op     = C_CLIP;
                state_next = ST_Q_CHK;
            end
            ST_Q_CHK:
            begin
                if (status.raw_empty || status.head_end)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    cmd.op     = C_CUR_HEAD;
                    state_next = ST_Q_WAIT;
                end
            end
            ST_Q_WAIT:
            begin
                state_next = ST_Q_VIS;
            end
            ST_Q_VIS:
            begin
                if (status.node_end)
                begin
                    state_next = ST_FINISH;
                end
                else if (status.ov)
                begin
                    cmd.op     = C_HIT;
                    state_next = ST_FINISH;
                end
                else if (status.below)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    cmd.op     = C_CUR_NEXT;
                    state_next = ST_Q_WAIT;
                end
            end
            ST_RF_WAIT:
            begin
                state_next = ST_RF_RES;
            end
            ST_RF_RES:
            begin
                cmd.op     = C_RES;
                state_next = ST_FINISH;
            end
            ST_RN_WAIT:
            begin
                state_next = ST_RN_LINK;
            end
            ST_RN_LINK:
            begin
                cmd.op     = C_CUR_NEXT;
                state_next = ST_RN_CHK;
            end
            ST_RN_CHK:
            begin
                state_next = status.node_end ? ST_FINISH : ST_RF_WAIT;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (publish)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// File: hw/rtl/drs_dp.sv
// ----------------------------------------------------------------------------
// drs_dp: rectangle pool datapath
// Border registers, rectangle and link memories, piece stack, list
// pointers, comparators and the result register.
// ----------------------------------------------------------------------------
module drs_dp (
    input  logic                clk,
    input  logic                rst_n,
    input  drs_pkg::in_item_t   in_data,
    input  logic                cfg_valid,
    input  drs_pkg::cfg_idx_t   cfg_index,
    input  drs_pkg::coord_t     cfg_data,
    input  drs_pkg::cmd_t       cmd,
    output drs_pkg::status_t    status,
    output drs_pkg::out_item_t  out_data
);
    import drs_pkg::*;

    box_t rect_mem [POOL_DEPTH];
    logic [PTR_W-1:0] link_mem [POOL_DEPTH];
    box_t stack_mem [STACK_DEPTH];

    box_t             rect_rd_reg;
    logic [PTR_W-1:0] link_rd_reg;
    box_t             stack_rd_reg;

    box_t              border_reg, border_next;
    logic [PTR_W-1:0]  head_reg, head_next;
    logic [PTR_W-1:0]  cursor_reg, cursor_next;
    logic [PTR_W-1:0]  count_reg, count_next;
    logic              whole_reg, whole_next;
    logic [POOL_DEPTH-1:0] used_reg, used_next;
    logic [SP_W-1:0]   sp_reg, sp_next;

    op_t               op_reg, op_next;
    box_t              q_reg, q_next;
    box_t              x_reg, x_next;
    box_t              a_reg, a_next;
    logic [PTR_W-1:0]  prev_reg, prev_next;
    logic [PTR_W-1:0]  node_reg, node_next;
    logic [PTR_W-1:0]  rprev_reg, rprev_next;
    logic [IDX_W-1:0]  slot_reg, slot_next;
    logic              hit_reg, hit_next;
    logic              rv_reg, rv_next;
    box_t              res_reg, res_next;
    out_item_t         out_reg, out_next;

    logic              rect_we, link_we, stk_we;
    logic [IDX_W-1:0]  rect_wa, link_wa;
    logic [SIDX_W-1:0] stk_wa;
    box_t              rect_wd, stk_wd;
    logic [PTR_W-1:0]  link_wd;

    logic [IDX_W-1:0]  free_idx;
    logic [SP_W-1:0]   sp_m1;
    box_t              c, split_p, rem_p;
    coord_t            mvt, mvb, rvt, rvb;

    assign c     = rect_rd_reg;
    assign sp_m1 = sp_reg - SP_W'(1);

    always_comb
    begin
        free_idx = '0;
        for (int i = POOL_DEPTH - 1; i >= 0; i--)
        begin
            if (!used_reg[i])
            begin
                free_idx = IDX_W'(i);
            end
        end
    end

    assign mvt = cmax(c.t, x_reg.t);
    assign mvb = cmin(c.b, x_reg.b);
    assign rvt = cmax(q_reg.t, a_reg.t);
    assign rvb = cmin(a_reg.b, q_reg.b);

    always_comb
    begin
        case (cmd.sel)
            2'd0:    split_p = '{l: x_reg.l, t: c.b, r: x_reg.r, b: x_reg.b};
            2'd1:    split_p = '{l: x_reg.l, t: x_reg.t, r: x_reg.r, b: c.t};
            2'd2:    split_p = '{l: c.r, t: mvt, r: x_reg.r, b: mvb};
            default: split_p = '{l: x_reg.l, t: mvt, r: c.l, b: mvb};
        endcase
        case (cmd.sel)
            2'd0:    rem_p = '{l: a_reg.l, t: a_reg.t, r: a_reg.r, b: q_reg.t};
            2'd1:    rem_p = '{l: a_reg.l, t: rvt, r: q_reg.l, b: rvb};
            2'd2:    rem_p = '{l: q_reg.r, t: rvt, r: a_reg.r, b: rvb};
            default: rem_p = '{l: a_reg.l, t: q_reg.b, r: a_reg.r, b: a_reg.b};
        endcase
    end

    always_comb
    begin
        status.op          = op_reg;
        status.whole       = whole_reg;
        status.full        = (count_reg >= PTR_W'(POOL_DEPTH));
        status.raw_empty   = (x_reg.l >= x_reg.r) || (x_reg.t >= x_reg.b);
        status.node_end    = (node_reg == NODE_END);
        status.head_end    = (head_reg == NODE_END);
        status.cursor_end  = (cursor_reg == NODE_END);
        status.cursor_used = used_reg[cursor_reg[IDX_W-1:0]];
        status.count_zero  = (count_reg == '0);
        status.sp_zero     = (sp_reg == '0);
        status.sp_full     = (sp_reg >= SP_W'(STACK_DEPTH));
        status.rprev_end   = (rprev_reg == NODE_END);
        status.ov          = (c.l < x_reg.r) && (c.r > x_reg.l)
                          && (c.t < x_reg.b) && (c.b > x_reg.t);
        status.x_in_c      = (x_reg.l >= c.l) && (x_reg.r <= c.r)
                          && (x_reg.t >= c.t) && (x_reg.b <= c.b);
        status.c_in_x      = (x_reg.l <= c.l) && (x_reg.r >= c.r)
                          && (x_reg.t <= c.t) && (x_reg.b >= c.b);
        status.ins_lt      = (c.t < x_reg.t);
        status.ins_le      = (c.t <= x_reg.t) && (c.l < x_reg.l);
        status.below       = (c.t > x_reg.b);
        status.ov_q        = (q_reg.l < c.r) && (q_reg.r > c.l)
                          && (q_reg.t < c.b) && (q_reg.b > c.t);
        status.split_need  = {x_reg.l < c.l, c.r < x_reg.r, x_reg.t < c.t, c.b < x_reg.b};
        status.rem_need    = {a_reg.b > q_reg.b, a_reg.r > q_reg.r,
                              a_reg.l < q_reg.l, a_reg.t < q_reg.t};
    end

    always_comb
    begin
        border_next = border_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_LEFT:   border_next.l = cfg_data;
                CFG_TOP:    border_next.t = cfg_data;
                CFG_RIGHT:  border_next.r = cfg_data;
                CFG_BOTTOM: border_next.b = cfg_data;
            endcase
        end
    end

    always_comb
    begin
        head_next   = head_reg;
        cursor_next = cursor_reg;
        count_next  = count_reg;
        whole_next  = whole_reg;
        used_next   = used_reg;
        sp_next     = sp_reg;
        op_next     = op_reg;
        q_next      = q_reg;
        x_next      = x_reg;
        a_next      = a_reg;
        prev_next   = prev_reg;
        node_next   = node_reg;
        rprev_next  = rprev_reg;
        slot_next   = slot_reg;
        hit_next    = hit_reg;
        rv_next     = rv_reg;
        res_next    = res_reg;
        out_next    = out_reg;
        rect_we     = 1'b0;
        rect_wa     = free_idx;
        rect_wd     = x_reg;
        link_we     = 1'b0;
        link_wa     = prev_reg[IDX_W-1:0];
        link_wd     = link_rd_reg;
        stk_we      = 1'b0;
        stk_wa      = sp_reg[SIDX_W-1:0];
        stk_wd      = split_p;
        unique case (cmd.op)
            C_NOP:
            begin
            end
            C_ACCEPT:
            begin
                op_next  = op_t'(in_data.opcode);
                q_next   = '{l: in_data.left_edge, t: in_data.top_edge,
                             r: in_data.right_edge, b: in_data.bottom_edge};
                hit_next = 1'b0;
                rv_next  = 1'b0;
                res_next = '0;
            end
            C_CLEAR:
            begin
                used_next   = '0;
                count_next  = '0;
                head_next   = NODE_END;
                cursor_next = NODE_END;
                whole_next  = 1'b0;
            end
            C_WHOLE:
            begin
                if (!whole_reg)
                begin
                    used_next   = '0;
                    count_next  = '0;
                    head_next   = NODE_END;
                    cursor_next = NODE_END;
                    whole_next  = 1'b1;
                end
            end
            C_LOAD_X:
            begin
                x_next = q_reg;
            end
            C_CLIP:
            begin
                x_next = clip_box(x_reg, border_reg);
            end
            C_PUSH_IN:
            begin
                stk_we  = 1'b1;
                stk_wa  = '0;
                stk_wd  = q_reg;
                sp_next = SP_W'(1);
            end
            C_POP:
            begin
                x_next  = stack_rd_reg;
                sp_next = sp_m1;
            end
            C_PUSH:
            begin
                stk_we  = 1'b1;
                sp_next = sp_reg + SP_W'(1);
            end
            C_NODE_HEAD:
            begin
                prev_next = NODE_END;
                node_next = head_reg;
            end
            C_NODE_NEXT:
            begin
                prev_next = node_reg;
                node_next = link_rd_reg;
            end
            C_NODE_LINK:
            begin
                node_next = link_rd_reg;
            end
            C_UNLINK:
            begin
                if (prev_reg == NODE_END)
                begin
                    head_next = link_rd_reg;
                end
                else
                begin
                    link_we = 1'b1;
                end
                used_next[node_reg[IDX_W-1:0]] = 1'b0;
                count_next = count_reg - PTR_W'(1);
                node_next  = link_rd_reg;
                a_next     = c;
                rprev_next = prev_reg;
            end
            C_ALLOC:
            begin
                slot_next           = free_idx;
                rect_we             = 1'b1;
                used_next[free_idx] = 1'b1;
                count_next          = count_reg + PTR_W'(1);
                prev_next           = NODE_END;
                node_next           = head_reg;
            end
            C_LINK_PREV:
            begin
                if (prev_reg == NODE_END)
                begin
                    head_next = PTR_W'(slot_reg);
                end
                else
                begin
                    link_we = 1'b1;
                    link_wd = PTR_W'(slot_reg);
                end
            end
            C_LINK_SLOT:
            begin
                link_we = 1'b1;
                link_wa = slot_reg;
                link_wd = node_reg;
            end
            C_LOAD_RP:
            begin
                x_next = rem_p;
            end
            C_RRESTORE:
            begin
                prev_next = rprev_reg;
                node_next = (rprev_reg == NODE_END) ? head_reg : rprev_reg;
            end
            C_CUR_HEAD:
            begin
                cursor_next = head_reg;
                node_next   = head_reg;
            end
            C_CUR_NEXT:
            begin
                cursor_next = link_rd_reg;
                node_next   = link_rd_reg;
            end
            C_NODE_CUR:
            begin
                node_next = cursor_reg;
            end
            C_CUR_END:
            begin
                cursor_next = NODE_END;
            end
            C_HIT:
            begin
                hit_next = 1'b1;
            end
            C_RES:
            begin
                rv_next  = 1'b1;
                res_next = c;
            end
            C_PUBLISH:
            begin
                out_next.hit          = hit_reg;
                out_next.rect_valid   = rv_reg;
                out_next.out_left     = res_reg.l;
                out_next.out_top      = res_reg.t;
                out_next.out_right    = res_reg.r;
                out_next.out_bottom   = res_reg.b;
                out_next.whole_mode   = whole_reg;
                out_next.stored_count = 6'(count_reg);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            border_reg <= '0;
            head_reg   <= NODE_END;
            cursor_reg <= NODE_END;
            count_reg  <= '0;
            whole_reg  <= 1'b0;
            used_reg   <= '0;
            sp_reg     <= '0;
        end
        else
        begin
            border_reg <= border_next;
            head_reg   <= head_next;
            cursor_reg <= cursor_next;
            count_reg  <= count_next;
            whole_reg  <= whole_next;
            used_reg   <= used_next;
            sp_reg     <= sp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        q_reg     <= q_next;
        x_reg     <= x_next;
        a_reg     <= a_next;
        prev_reg  <= prev_next;
        node_reg  <= node_next;
        rprev_reg <= rprev_next;
        slot_reg  <= slot_next;
        hit_reg   <= hit_next;
        rv_reg    <= rv_next;
        res_reg   <= res_next;
        out_reg   <= out_next;
    end

    always_ff @(posedge clk)
    begin
        if (rect_we)
        begin
            rect_mem[rect_wa] <= rect_wd;
        end
        rect_rd_reg <= rect_mem[node_reg[IDX_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (link_we)
        begin
            link_mem[link_wa] <= link_wd;
        end
        link_rd_reg <= link_mem[node_reg[IDX_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (stk_we)
        begin
            stack_mem[stk_wa] <= stk_wd;
        end
        stack_rd_reg <= stack_mem[sp_m1[SIDX_W-1:0]];
    end

    assign out_data = out_reg;

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: dirty rectangle set testbench
// Drives operations through a queue-fed driver, predicts each result with a
// behavioral copy of the rectangle pool and checks every result transfer.
// ----------------------------------------------------------------------------
module tb_top;
    import drs_pkg::*;

    localparam int PEND = POOL_DEPTH;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    in_item_t   in_data;
    logic       out_valid;
    logic       out_ready;
    out_item_t  out_data;
    logic       cfg_valid;
    logic       cfg_ready;
    cfg_idx_t   cfg_index;
    coord_t     cfg_data;

    dirty_rectangle_set_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // predictor state
    int         bd_l, bd_t, bd_r, bd_b;
    int         rl[PEND], rt[PEND], rr[PEND], rb[PEND];
    int         nxt[PEND];
    bit         used[PEND];
    int         head, cursor, count;
    bit         whole;
    int         sl[$], st[$], sr[$], sb[$];

    in_item_t   op_queue[$];
    out_item_t  result_queue[$];
    int         errors;
    int         hold_off;
    bit         calm;
    bit         cfg_busy;

    function automatic int mx(int a, int b);
        return a > b ? a : b;
    endfunction

    function automatic int mn(int a, int b);
        return a < b ? a : b;
    endfunction

    function automatic bit meets(int al, int at, int ar, int ab,
                                 int bl, int bt, int br, int bb);
        return al < br && ar > bl && at < bb && ab > bt;
    endfunction

    task automatic empty_set();
        for (int i = 0; i < PEND; i++)
        begin
            used[i] = 0;
            nxt[i] = PEND;
        end
        count = 0;
        head = PEND;
        cursor = PEND;
    endtask

    task automatic enter_whole();
        if (!whole)
        begin
            empty_set();
            whole = 1;
        end
    endtask

    task automatic set_link(int p, int v);
        if (p == PEND)
            head = v;
        else
            nxt[p] = v;
    endtask

    task automatic admit(inout int l, inout int t, inout int r, inout int b,
                         output bit ok);
        ok = 0;
        if (whole)
            return;
        if (count >= PEND)
        begin
            enter_whole();
            return;
        end
        if (l >= r || t >= b)
            return;
        l = mx(l, bd_l);
        t = mx(t, bd_t);
        r = mn(r, bd_r);
        b = mn(b, bd_b);
        ok = l < r && t < b;
    endtask

    task automatic insert_sorted(int l, int t, int r, int b);
        int s;
        int p;
        int n;
        s = 0;
        while (s < PEND && used[s])
            s++;
        if (s >= PEND)
            return;
        rl[s] = l; rt[s] = t; rr[s] = r; rb[s] = b;
        used[s] = 1;
        count++;
        p = PEND;
        n = head;
        while (n != PEND && rt[n] < t)
        begin
            p = n;
            n = nxt[n];
        end
        while (n != PEND && rt[n] <= t && rl[n] < l)
        begin
            p = n;
            n = nxt[n];
        end
        set_link(p, s);
        nxt[s] = n;
    endtask

    task automatic add_direct(int l, int t, int r, int b);
        bit ok;
        admit(l, t, r, b, ok);
        if (ok)
            insert_sorted(l, t, r, b);
    endtask

    task automatic push_piece(int l, int t, int r, int b, output bit ok);
        ok = 1;
        if (sl.size() >= STACK_DEPTH)
        begin
            enter_whole();
            ok = 0;
            return;
        end
        sl.push_back(l); st.push_back(t); sr.push_back(r); sb.push_back(b);
    endtask

    task automatic add_merge(int l0, int t0, int r0, int b0);
        int l, t, r, b, p, n, vt, vb;
        bit again, ok, placed;
        sl.delete(); st.delete(); sr.delete(); sb.delete();
        push_piece(l0, t0, r0, b0, ok);
        while (sl.size() > 0 && !whole)
        begin
            l = sl.pop_back(); t = st.pop_back(); r = sr.pop_back(); b = sb.pop_back();
            again = 1;
            while (again)
            begin
                again = 0;
                admit(l, t, r, b, ok);
                if (!ok)
                    break;
                p = PEND;
                n = head;
                placed = 0;
                while (n != PEND)
                begin
                    if (meets(rl[n], rt[n], rr[n], rb[n], l, t, r, b))
                    begin
                        placed = 1;
                        if (l >= rl[n] && r <= rr[n] && t >= rt[n] && b <= rb[n])
                            break;
                        if (l <= rl[n] && r >= rr[n] && t <= rt[n] && b >= rb[n])
                        begin
                            set_link(p, nxt[n]);
                            used[n] = 0;
                            nxt[n] = PEND;
                            count--;
                            again = 1;
                            break;
                        end
                        vt = mx(rt[n], t);
                        vb = mn(rb[n], b);
                        if (rb[n] < b)
                        begin
                            push_piece(l, rb[n], r, b, ok);
                            if (!ok) return;
                        end
                        if (t < rt[n])
                        begin
                            push_piece(l, t, r, rt[n], ok);
                            if (!ok) return;
                        end
                        if (rr[n] < r)
                        begin
                            push_piece(rr[n], vt, r, vb, ok);
                            if (!ok) return;
                        end
                        if (l < rl[n])
                        begin
                            push_piece(l, vt, rl[n], vb, ok);
                            if (!ok) return;
                        end
                        break;
                    end
                    p = n;
                    n = nxt[n];
                end
                if (!placed)
                    insert_sorted(l, t, r, b);
            end
        end
    endtask

    task automatic remove_area(int l, int t, int r, int b);
        int p, n, al, at, ar, ab, vt, vb;
        if (count == 0)
            return;
        p = PEND;
        n = head;
        while (n != PEND)
        begin
            al = rl[n]; at = rt[n]; ar = rr[n]; ab = rb[n];
            if (meets(l, t, r, b, al, at, ar, ab))
            begin
                set_link(p, nxt[n]);
                used[n] = 0;
                nxt[n] = PEND;
                count--;
                vt = mx(t, at);
                vb = mn(ab, b);
                if (at < t) add_direct(al, at, ar, t);
                if (al < l) add_direct(al, vt, l, vb);
                if (ar > r) add_direct(r, vt, ar, vb);
                if (ab > b) add_direct(al, b, ar, ab);
                if (whole)
                    return;
                n = (p == PEND) ? head : nxt[p];
                continue;
            end
            p = n;
            n = nxt[n];
        end
    endtask

    task automatic query_area(int l, int t, int r, int b, output bit hit);
        hit = 0;
        if (whole)
        begin
            hit = 1;
            return;
        end
        l = mx(l, bd_l);
        t = mx(t, bd_t);
        r = mn(r, bd_r);
        b = mn(b, bd_b);
        if (l >= r || t >= b || head == PEND)
            return;
        cursor = head;
        while (cursor != PEND)
        begin
            if (meets(l, t, r, b, rl[cursor], rt[cursor], rr[cursor], rb[cursor]))
            begin
                hit = 1;
                return;
            end
            if (rt[cursor] > b)
                return;
            cursor = nxt[cursor];
        end
    endtask

    task automatic predict_set_op(in_item_t it);
        out_item_t o;
        int l, t, r, b;
        bit h;
        l = it.left_edge; t = it.top_edge; r = it.right_edge; b = it.bottom_edge;
        o = '0;
        case (op_t'(it.opcode))
            OP_CLEAR:
            begin
                empty_set();
                whole = 0;
            end
            OP_ADD_MERGE:  add_merge(l, t, r, b);
            OP_WHOLE:      enter_whole();
            OP_REMOVE:     remove_area(l, t, r, b);
            OP_QUERY:
            begin
                query_area(l, t, r, b, h);
                o.hit = h;
            end
            OP_READ_FIRST:
            begin
                if (head != PEND)
                begin
                    cursor = head;
                    o.rect_valid = 1;
                end
            end
            OP_READ_NEXT:
            begin
                if (cursor >= PEND || !used[cursor])
                    cursor = PEND;
                else
                begin
                    cursor = nxt[cursor];
                    if (cursor < PEND)
                        o.rect_valid = 1;
                    else
                        cursor = PEND;
                end
            end
            default:       add_direct(l, t, r, b);
        endcase
        if (o.rect_valid)
        begin
            o.out_left = rl[cursor];
            o.out_top = rt[cursor];
            o.out_right = rr[cursor];
            o.out_bottom = rb[cursor];
        end
        o.whole_mode = whole;
        o.stored_count = 6'(count);
        result_queue.push_back(o);
    endtask

    initial
    begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 0;
            in_data <= '0;
        end
        else if (!in_valid || in_ready)
        begin
            if (in_valid)
                predict_set_op(in_data);
            if (op_queue.size() > 0 && (calm || $urandom_range(99) >= 18))
            begin
                in_valid <= 1;
                in_data <= op_queue.pop_front();
            end
            else
                in_valid <= 0;
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (result_queue.size() == 0)
                begin
                    $display("%0t: unexpected result %p", $realtime, out_data);
                    errors++;
                end
                else
                begin
                    out_item_t e;
                    e = result_queue.pop_front();
                    if (out_data.hit !== e.hit)
                        $display("%0t: hit exp %0d got %0d", $realtime, e.hit, out_data.hit);
                    if (out_data.rect_valid !== e.rect_valid)
                        $display("%0t: rect_valid exp %0d got %0d", $realtime,
                                 e.rect_valid, out_data.rect_valid);
                    if (out_data.out_left !== e.out_left)
                        $display("%0t: out_left exp %0d got %0d", $realtime,
                                 e.out_left, out_data.out_left);
                    if (out_data.out_top !== e.out_top)
                        $display("%0t: out_top exp %0d got %0d", $realtime,
                                 e.out_top, out_data.out_top);
                    if (out_data.out_right !== e.out_right)
                        $display("%0t: out_right exp %0d got %0d", $realtime,
                                 e.out_right, out_data.out_right);
                    if (out_data.out_bottom !== e.out_bottom)
                        $display("%0t: out_bottom exp %0d got %0d", $realtime,
                                 e.out_bottom, out_data.out_bottom);
                    if (out_data.whole_mode !== e.whole_mode)
                        $display("%0t: whole_mode exp %0d got %0d", $realtime,
                                 e.whole_mode, out_data.whole_mode);
                    if (out_data.stored_count !== e.stored_count)
                        $display("%0t: stored_count exp %0d got %0d", $realtime,
                                 e.stored_count, out_data.stored_count);
                    if (out_data !== e)
                        errors++;
                end
            end
            if (hold_off > 0)
            begin
                hold_off <= hold_off - 1;
                out_ready <= 0;
            end
            else
                out_ready <= calm || $urandom_range(99) >= 18;
        end
    end

    function automatic coord_t rnd_coord();
        case ($urandom_range(3))
            0:       return coord_t'($urandom);
            1:       return coord_t'($urandom_range(6) * 16 - 8);
            default: return coord_t'($urandom_range(100) - 4);
        endcase
    endfunction

    task automatic queue_op(op_t op, int l, int t, int r, int b);
        in_item_t it;
        it.opcode = op;
        it.left_edge = coord_t'(l);
        it.top_edge = coord_t'(t);
        it.right_edge = coord_t'(r);
        it.bottom_edge = coord_t'(b);
        op_queue.push_back(it);
    endtask

    task automatic queue_random(int n);
        int l, t;
        op_t op;
        for (int i = 0; i < n; i++)
        begin
            case ($urandom_range(19))
                0:           op = OP_CLEAR;
                1:           op = OP_WHOLE;
                2, 3, 4, 5:  op = OP_REMOVE;
                6, 7:        op = OP_QUERY;
                8:           op = OP_READ_FIRST;
                9, 10:       op = OP_READ_NEXT;
                11, 12:      op = OP_ADD_DIRECT;
                default:     op = OP_ADD_MERGE;
            endcase
            if ($urandom_range(9) == 0)
                queue_op(op, rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord());
            else
            begin
                l = rnd_coord();
                t = rnd_coord();
                queue_op(op, l, t, l + $urandom_range(40) - 2, t + $urandom_range(40) - 2);
            end
        end
    endtask

    task automatic write_border(int l, int t, int r, int b);
        int v[4];
        v = '{l, t, r, b};
        cfg_busy = 1;
        for (int i = 0; i < 4; i++)
        begin
            cfg_valid <= 1;
            cfg_index <= cfg_idx_t'(i);
            cfg_data <= coord_t'(v[i]);
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
        end
        cfg_valid <= 0;
        bd_l = coord_t'(l); bd_t = coord_t'(t); bd_r = coord_t'(r); bd_b = coord_t'(b);
        cfg_busy = 0;
    endtask

    task automatic drain();
        while (op_queue.size() > 0 || in_valid || result_queue.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    initial
    begin
        rst_n = 0;
        cfg_valid = 0;
        cfg_index = CFG_LEFT;
        cfg_data = '0;
        errors = 0;
        hold_off = 0;
        calm = 0;
        bd_l = 0; bd_t = 0; bd_r = 0; bd_b = 0;
        whole = 0;
        empty_set();
        repeat (11) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // empty border: everything clips away
        queue_op(OP_ADD_MERGE, 0, 0, 10, 10);
        queue_op(OP_QUERY, -32768, -32768, 32767, 32767);
        queue_op(OP_READ_FIRST, 0, 0, 0, 0);
        queue_op(OP_READ_NEXT, 0, 0, 0, 0);
        drain();

        write_border(-32768, -32768, 32767, 32767);
        queue_op(OP_REMOVE, 0, 0, 5, 5);
        queue_op(OP_ADD_MERGE, -32768, -32768, 32767, 32767);
        queue_op(OP_ADD_MERGE, 0, 0, 10, 10);
        queue_op(OP_CLEAR, 0, 0, 0, 0);
        queue_op(OP_ADD_MERGE, 0, 0, 20, 20);
        queue_op(OP_ADD_MERGE, 10, 10, 30, 30);
        queue_op(OP_ADD_MERGE, -5, -5, 40, 40);
        queue_op(OP_ADD_DIRECT, 5, 5, 5, 9);
        queue_op(OP_ADD_DIRECT, 50, 50, 60, 60);
        queue_op(OP_REMOVE, 52, 52, 55, 55);
        queue_op(OP_QUERY, 53, 53, 54, 54);
        queue_op(OP_QUERY, 100, 100, 110, 110);
        queue_op(OP_READ_FIRST, 0, 0, 0, 0);
        queue_op(OP_READ_NEXT, 0, 0, 0, 0);
        queue_op(OP_REMOVE, 32767, -32768, -32768, 32767);
        queue_op(OP_WHOLE, 0, 0, 0, 0);
        queue_op(OP_WHOLE, 0, 0, 0, 0);
        queue_op(OP_QUERY, 0, 0, 0, 0);
        queue_op(OP_ADD_DIRECT, 0, 0, 4, 4);
        queue_op(OP_CLEAR, 0, 0, 0, 0);
        for (int i = 0; i < 34; i++)
            queue_op(OP_ADD_DIRECT, i * 4, 0, i * 4 + 2, 2);
        queue_op(OP_CLEAR, 0, 0, 0, 0);
        drain();

        // long receiver stall while the sender keeps offering
        hold_off = 300;
        queue_random(40);
        drain();

        write_border(0, 0, 64, 48);
        queue_random(250);
        drain();

        write_border(16, 8, 80, 90);
        calm = 1;
        queue_random(150);
        drain();
        calm = 0;

        write_border(-20, -20, 20, 20);
        queue_random(250);
        drain();

        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #200ms;
        $display("Test completed with failures");
        $finish;
    end
endmodule
